@@ rtl/utf8_byte_decoder_assert.svh @@
// assertion macros for the utf8 byte decoder
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef UTF8_BYTE_DECODER_ASSERT_SVH
`define UTF8_BYTE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked at every edge outside reset
`define UBD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("utf8 decoder check failed");

// consequence checked in the cycle after the antecedent
`define UBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder sequence check failed");

`else

`define UBD_ASSERT(lbl, clk, rst_n, prop)
`define UBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/utf8d_pkg.sv @@
// shared types and constants of the utf8 byte decoder
// no dependencies
package utf8d_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] CP_MALFORMED = 16'h003F;
  localparam logic [15:0] CP_REPLACE   = 16'hFFFD;

  // held byte count codes
  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_LEAD = 2'd1;

  // bytes dropped after a four-byte lead
  localparam logic [1:0] SKIP_FOUR = 2'd3;

  // one queue word: one or two code points from one input byte
  typedef struct packed {
    logic        two;
    logic [15:0] cp0;
    logic [15:0] cp1;
  } entry_t;

  typedef struct packed {
    logic [1:0] held_count;
    logic [1:0] skip_left;
  } front_stat_t;

endpackage

@@ rtl/utf8d_front.sv @@
// front end: accepts bytes, tracks held lead state, forms queue words
// depends on utf8d_pkg
module utf8d_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [7:0]             byte_value,
  input  logic                   string_end,
  output logic                   push,
  output utf8d_pkg::entry_t      push_data,
  output utf8d_pkg::front_stat_t stat
);

  logic [7:0] held_lead_r, held_lead_nxt;
  logic [7:0] held_follow_r, held_follow_nxt;
  logic [1:0] held_count_r, held_count_nxt;
  logic [1:0] skip_left_r, skip_left_nxt;
  logic       emit;

  logic is_ascii, is_lead2, is_lead3, is_lead4;
  logic held_is_lead2;

  // single byte decode with the string treated as ending here
  function automatic logic [15:0] fresh_cp(input logic [7:0] b);
    logic [15:0] cp;
    if (!b[7]) begin
      cp = {8'd0, b};
    end else if (b[7:3] == 5'b11110) begin
      cp = utf8d_pkg::CP_REPLACE;
    end else begin
      cp = utf8d_pkg::CP_MALFORMED;
    end
    return cp;
  endfunction

  assign is_ascii      = !byte_value[7];
  assign is_lead2      = (byte_value[7:5] == 3'b110);
  assign is_lead3      = (byte_value[7:4] == 4'b1110);
  assign is_lead4      = (byte_value[7:3] == 5'b11110);
  assign held_is_lead2 = (held_lead_r[7:5] == 3'b110);

  always_comb begin
    held_lead_nxt   = held_lead_r;
    held_follow_nxt = held_follow_r;
    held_count_nxt  = held_count_r;
    skip_left_nxt   = skip_left_r;
    emit            = 1'b0;
    push_data.two   = 1'b0;
    push_data.cp0   = utf8d_pkg::CP_MALFORMED;
    push_data.cp1   = fresh_cp(byte_value);

    if (skip_left_r != 2'd0) begin
      skip_left_nxt = skip_left_r - 2'd1;
    end else if (held_count_r == utf8d_pkg::HELD_LEAD) begin
      if (held_is_lead2) begin
        emit           = 1'b1;
        push_data.cp0  = {5'd0, held_lead_r[4:0], byte_value[5:0]};
        held_count_nxt = utf8d_pkg::HELD_NONE;
        held_lead_nxt  = 8'd0;
      end else if (string_end) begin
        // truncated three-byte lead: '?' then this byte on its own
        emit           = 1'b1;
        push_data.two  = 1'b1;
        held_count_nxt = utf8d_pkg::HELD_NONE;
        held_lead_nxt  = 8'd0;
      end else begin
        held_follow_nxt = byte_value;
        held_count_nxt  = held_count_r + 2'd1;
      end
    end else if (held_count_r != utf8d_pkg::HELD_NONE) begin
      emit            = 1'b1;
      push_data.cp0   = {held_lead_r[3:0], held_follow_r[5:0], byte_value[5:0]};
      held_count_nxt  = utf8d_pkg::HELD_NONE;
      held_lead_nxt   = 8'd0;
      held_follow_nxt = 8'd0;
    end else begin
      if (is_ascii) begin
        emit          = 1'b1;
        push_data.cp0 = {8'd0, byte_value};
      end else if (is_lead2 || is_lead3) begin
        if (string_end) begin
          emit = 1'b1;
        end else begin
          held_lead_nxt  = byte_value;
          held_count_nxt = utf8d_pkg::HELD_LEAD;
        end
      end else if (is_lead4) begin
        emit          = 1'b1;
        push_data.cp0 = utf8d_pkg::CP_REPLACE;
        skip_left_nxt = utf8d_pkg::SKIP_FOUR;
      end else begin
        emit = 1'b1;
      end
    end

    if (string_end) begin
      held_lead_nxt   = 8'd0;
      held_follow_nxt = 8'd0;
      held_count_nxt  = utf8d_pkg::HELD_NONE;
      skip_left_nxt   = 2'd0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_lead_r   <= 8'd0;
      held_follow_r <= 8'd0;
      held_count_r  <= utf8d_pkg::HELD_NONE;
      skip_left_r   <= 2'd0;
    end else if (accept) begin
      held_lead_r   <= held_lead_nxt;
      held_follow_r <= held_follow_nxt;
      held_count_r  <= held_count_nxt;
      skip_left_r   <= skip_left_nxt;
    end
  end

  assign stat.held_count = held_count_r;
  assign stat.skip_left  = skip_left_r;

endmodule

@@ rtl/utf8d_queue.sv @@
// short register queue of decoded words between front and back
// depends on utf8d_pkg
module utf8d_queue #(
  parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  utf8d_pkg::entry_t push_data,
  input  logic              pop,
  output utf8d_pkg::entry_t pop_data,
  output logic              empty,
  output logic              full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8d_pkg::entry_t  mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/utf8d_back.sv @@
// back end: unpacks queue words into single results in an output register
// depends on utf8d_pkg
module utf8d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  utf8d_pkg::entry_t pop_data,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [15:0]       out_code_point,
  output logic              out_run_last,
  output logic              pend
);

  logic        out_valid_r;
  logic [15:0] out_code_point_r;
  logic        out_run_last_r;
  logic        pend_r;
  logic [15:0] second_cp_r;
  logic        load;

  // output register free or being taken this cycle
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !pend_r && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= !empty;
        pend_r      <= !empty && pop_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_code_point_r <= second_cp_r;
        out_run_last_r   <= 1'b1;
      end else begin
        out_code_point_r <= pop_data.cp0;
        out_run_last_r   <= !pop_data.two;
        second_cp_r      <= pop_data.cp1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;
  assign out_run_last   = out_run_last_r;
  assign pend           = pend_r;

endmodule

@@ rtl/utf8_byte_decoder.sv @@
// utf8 byte decoder: one byte in per cycle unless stalled, 16-bit code points out
// path: a byte's result goes through the queue, then the output register, to out_*
// throughput: one byte per cycle unless stalled; a byte with two results
// holds the output for both, and the front-back queue (QUEUE_DEPTH words) absorbs that
// reset: synchronous rst_n low empties the queue, clears held bytes and the output
`include "utf8_byte_decoder_assert.svh"

module utf8_byte_decoder #(
  parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_string_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_point,
  output logic        out_run_last
);

  logic                   accept;
  logic                   q_push, q_pop, q_empty, q_full;
  utf8d_pkg::entry_t      q_push_data, q_pop_data;
  utf8d_pkg::front_stat_t front_stat;
  logic                   pend;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  utf8d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .byte_value (in_byte_value),
    .string_end (in_string_end),
    .push       (q_push),
    .push_data  (q_push_data),
    .stat       (front_stat)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  utf8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (q_empty),
    .pop_data       (q_pop_data),
    .pop            (q_pop),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_code_point (out_code_point),
    .out_run_last   (out_run_last),
    .pend           (pend)
  );

  // a word is never written into a full queue
  `UBD_ASSERT(a_no_overflow, clk, rst_n, q_push |-> !q_full)
  // a pending second result always sits behind a shown first one
  `UBD_ASSERT(a_pend_shown, clk, rst_n, pend |-> out_valid)
  // a result that is not the last of its byte has its partner pending
  `UBD_ASSERT(a_first_of_two, clk, rst_n, (out_valid && !out_run_last) |-> pend)
  // the final byte of a string leaves nothing held and nothing to skip
  `UBD_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && in_string_end,
                   front_stat.held_count == utf8d_pkg::HELD_NONE && front_stat.skip_left == 2'd0)

endmodule
